@@ design/mfmid_pkg.sv @@
package mfmid_pkg;

    localparam int POS_W = 15;
    localparam int SEC_W = 6;

    localparam logic [7:0] SYNC_BYTE    = 8'hA1;
    localparam logic [7:0] ID_MARK      = 8'hFE;
    localparam logic [7:0] DATA_MARK    = 8'hFB;
    localparam logic [7:0] DELETED_MARK = 8'hF8;

    localparam logic EV_ID   = 1'b0;
    localparam logic EV_DATA = 1'b1;

    localparam logic [1:0] SYNC_RUN_FULL = 2'd3;
    localparam logic [2:0] CHRN_LEN      = 3'd4;
    localparam logic [2:0] ID_FIELD_LEN  = 3'd6;

    localparam logic [POS_W-1:0] SECTOR_BYTES_BASE = 15'd128;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef struct packed {
        logic [7:0] track_byte;
        logic       track_start;
    } track_item_t;

    typedef struct packed {
        logic             event_kind;
        logic [SEC_W-1:0] sector_index;
        logic [7:0]       cylinder;
        logic [7:0]       head;
        logic [7:0]       record;
        logic [7:0]       size_code;
        logic [POS_W-1:0] sector_bytes;
        logic             id_crc_error;
        logic             deleted_mark;
        logic             repeat_mark;
        logic [POS_W-1:0] data_start;
    } event_item_t;

    typedef struct packed {
        logic [1:0]       sync_run;
        logic [2:0]       field_count;
        logic             in_id_field;
        logic [15:0]      crc;
        logic [3:0][7:0]  id_bytes;
        logic             sector_open;
        logic             data_seen;
        logic [POS_W-1:0] first_data_pos;
        logic [SEC_W-1:0] sector_counter;
        logic [POS_W-1:0] byte_position;
    } mfmid_state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_PRELOAD =
        crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, SYNC_BYTE), SYNC_BYTE), SYNC_BYTE),
                 ID_MARK);

    localparam mfmid_state_t STATE_RESET = '{
        sync_run:       2'd0,
        field_count:    3'd0,
        in_id_field:    1'b0,
        crc:            CRC_INIT,
        id_bytes:       '0,
        sector_open:    1'b0,
        data_seen:      1'b0,
        first_data_pos: '0,
        sector_counter: '0,
        byte_position:  '0
    };

endpackage

@@ design/mfmid_mark_logic.sv @@
module mfmid_mark_logic
    import mfmid_pkg::*;
#(
    parameter logic [POS_W-1:0] POS_CAP = 15'd16384,
    parameter logic [SEC_W-1:0] SEC_CAP = 6'd63
)
(
    input  mfmid_state_t state_cur,
    input  track_item_t  item,
    output mfmid_state_t state_next,
    output logic         produce,
    output event_item_t  result
);

    mfmid_state_t     s;
    logic [7:0]       b;
    logic             handled;
    logic             rep;
    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] pos_sat;

    always_comb
    begin
        b        = item.track_byte;
        s        = item.track_start ? STATE_RESET : state_cur;
        handled  = 1'b0;
        rep      = 1'b0;
        produce  = 1'b0;
        result   = '0;
        pos_inc  = {1'b0, s.byte_position} + {{POS_W{1'b0}}, 1'b1};
        pos_sat  = (pos_inc > {1'b0, POS_CAP}) ? POS_CAP : pos_inc[POS_W-1:0];

        if (s.sync_run == SYNC_RUN_FULL)
        begin
            s.sync_run = 2'd0;
            if ((b == DATA_MARK || b == DELETED_MARK) && s.sector_open)
            begin
                rep = s.data_seen;
                if (!s.data_seen)
                begin
                    s.data_seen      = 1'b1;
                    s.first_data_pos = pos_sat;
                end
                result.event_kind   = EV_DATA;
                result.sector_index = s.sector_counter;
                result.deleted_mark = (b == DELETED_MARK);
                result.repeat_mark  = rep;
                result.data_start   = s.first_data_pos;
                produce = 1'b1;
                handled = 1'b1;
            end
            else if (b == ID_MARK)
            begin
                if (s.sector_open && s.sector_counter < SEC_CAP)
                begin
                    s.sector_counter = s.sector_counter + 1'b1;
                end
                s.sector_open    = 1'b1;
                s.in_id_field    = 1'b1;
                s.field_count    = 3'd0;
                s.crc            = CRC_PRELOAD;
                s.id_bytes       = '0;
                s.data_seen      = 1'b0;
                s.first_data_pos = '0;
                handled = 1'b1;
            end
        end

        if (!handled)
        begin
            s.sync_run = (b == SYNC_BYTE) ? s.sync_run + 2'd1 : 2'd0;
            if (s.in_id_field)
            begin
                if (s.field_count < CHRN_LEN)
                begin
                    s.id_bytes[s.field_count[1:0]] = b;
                end
                s.crc         = crc_byte(s.crc, b);
                s.field_count = s.field_count + 3'd1;
                if (s.field_count >= ID_FIELD_LEN)
                begin
                    s.in_id_field = 1'b0;
                    s.field_count = ID_FIELD_LEN;
                    result.event_kind   = EV_ID;
                    result.sector_index = s.sector_counter;
                    result.cylinder     = s.id_bytes[0];
                    result.head         = s.id_bytes[1];
                    result.record       = s.id_bytes[2];
                    result.size_code    = s.id_bytes[3];
                    result.sector_bytes = SECTOR_BYTES_BASE << s.id_bytes[3][2:0];
                    result.id_crc_error = (s.crc != 16'h0000);
                    produce = 1'b1;
                end
            end
        end

        s.byte_position = pos_sat;
        state_next = s;
    end

endmodule

@@ design/mfm_sector_id_mark_detector.sv @@
// Watches decoded MFM track bytes for address marks (three A1 sync bytes and a mark byte),
// captures ID fields with a CRC-16-CCITT check and reports ID and data-mark transactions.
// One track byte is taken every cycle unless the input stalls; a byte waits in the input
// register; its event, if any, enters the result register as it leaves. The input stalls only
// when the byte at hand produces an event while the result register is full and stalled.
module mfm_sector_id_mark_detector
    import mfmid_pkg::*;
#(
    parameter int TRACK_BYTES_MAX = 16384,
    parameter int MAX_SECTORS     = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        track_valid,
    output logic        track_stall,
    input  track_item_t track_item,
    output logic        event_valid,
    input  logic        event_stall,
    output event_item_t event_item
);

    localparam int POS_CAP_INT = (TRACK_BYTES_MAX > 32767) ? 32767 : TRACK_BYTES_MAX;
    localparam int SEC_CAP_INT = (MAX_SECTORS - 1 > 63) ? 63 : MAX_SECTORS - 1;
    localparam logic [POS_W-1:0] POS_CAP = POS_CAP_INT[POS_W-1:0];
    localparam logic [SEC_W-1:0] SEC_CAP = SEC_CAP_INT[SEC_W-1:0];

    logic         in_valid_reg;
    track_item_t  in_item_reg;
    mfmid_state_t state_reg;
    mfmid_state_t state_next;
    logic         produce;
    event_item_t  result;
    logic         advance;
    logic         out_valid_reg;
    event_item_t  out_item_reg;

    mfmid_mark_logic #(
        .POS_CAP (POS_CAP),
        .SEC_CAP (SEC_CAP)
    ) u_mark_logic (
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .produce    (produce),
        .result     (result)
    );

    assign advance     = in_valid_reg && (!produce || !out_valid_reg || !event_stall);
    assign track_stall = in_valid_reg && !advance;
    assign event_valid = out_valid_reg;
    assign event_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (track_valid && !track_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg <= state_next;
            end

            if (advance && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!event_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (track_valid && !track_stall)
        begin
            in_item_reg <= track_item;
        end
        if (advance && produce)
        begin
            out_item_reg <= result;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_item.event_kind == EV_ID |->
        !event_item.deleted_mark && !event_item.repeat_mark && event_item.data_start == '0
        && $onehot(event_item.sector_bytes))
    else $error("ID transaction carries data-mark fields or bad sector size");

    assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_item.event_kind == EV_DATA |->
        event_item.data_start != '0 && !event_item.id_crc_error
        && event_item.sector_bytes == '0)
    else $error("data-mark transaction fields inconsistent");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.field_count <= ID_FIELD_LEN
        && (!state_reg.in_id_field || state_reg.sector_open))
    else $error("ID field capture state inconsistent");

    assert property (@(posedge clk) disable iff (!rst_n)
        track_stall |-> produce && out_valid_reg && event_stall)
    else $error("input stalled without a blocked transaction");

endmodule
